// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/blc_pkg.sv -----
package blc_pkg;

   localparam int IDX_W   = 12;
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int FAULT_W = 2;
   localparam int LEN_W   = 13;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [FAULT_W-1:0] fault_type;

   localparam kind_type KIND_LOAD  = 2'd0;
   localparam kind_type KIND_OPEN  = 2'd1;
   localparam kind_type KIND_CLOSE = 2'd2;

   localparam fault_type FAULT_OK       = 2'd0;
   localparam fault_type FAULT_NO_MATCH = 2'd1;
   localparam fault_type FAULT_EMPTY    = 2'd2;
   localparam fault_type FAULT_OVERFLOW = 2'd3;

   localparam byte_type CH_OPEN  = 8'h5B;
   localparam byte_type CH_CLOSE = 8'h5D;

endpackage

// ----- hw/rtl/bracket_loop_controller_top.sv -----
// Load, push, pop, no-op and the empty/overflow faults raise the result strobe in
// the cycle after start; a close with nonzero cell reads the return stack, then
// passes through the TOS state before the strobe. Open with zero cell scans one
// byte per cycle on the single program read port until a match or the limit.
// Throughput: the former ops take a word every cycle, else busy holds start off;
// receiver cannot stall. Sync reset clears control, stack count, program_length.
`include "assert_macros.svh"

module bracket_loop_controller_top
   import blc_pkg::*;
#(
   parameter int PROGRAM_DEPTH = 4096,
   parameter int STACK_DEPTH   = 64
) (
   input  logic             clock,
   input  logic             reset,
   // command channel
   input  logic             start,
   output logic             busy,
   input  kind_type         req_kind,
   input  idx_type          req_address,
   input  byte_type         req_program_byte,
   input  byte_type         req_cell_value,
   // result channel, one-cycle strobe, no back-pressure
   output logic             rsp_strobe,
   output idx_type          rsp_next_index,
   output fault_type        rsp_fault,
   // program_length register write
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_program_length
);

   // Program store address width, scan pointer width (must hold the
   // limit itself and also address+1 for the 12-bit address field).
   localparam int PA_W = $clog2(PROGRAM_DEPTH);
   localparam int CW   = (PA_W + 1 > LEN_W) ? PA_W + 1 : LEN_W;
   // Return stack index and count widths.
   localparam int SI_W = $clog2(STACK_DEPTH);
   localparam int SC_W = $clog2(STACK_DEPTH + 1);

   localparam logic [CW-1:0]   PD_CW   = CW'(PROGRAM_DEPTH);
   localparam logic [SC_W-1:0] SD_FULL = SC_W'(STACK_DEPTH);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_TOS  = 2'd2;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] len_ff;
   idx_type          addr_ff, addr_in;
   logic [SC_W-1:0]  cnt_ff, cnt_in;

   // scan pipeline: rd_ptr is the next byte to fetch, rd_vld/rd_idx
   // qualify the byte coming out of the memory this cycle
   logic [CW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic             rd_vld_ff, rd_vld_in;
   idx_type          rd_idx_ff, rd_idx_in;
   logic [CW-1:0]    depth_ff, depth_in;

   logic             rsp_valid_ff, rsp_valid_in;
   idx_type          rsp_idx_ff, rsp_idx_in;
   fault_type        rsp_fault_ff, rsp_fault_in;

   // memories and their registered read data
   byte_type         prog_mem [PROGRAM_DEPTH];
   byte_type         prog_rd_ff;
   idx_type          stk_mem [STACK_DEPTH];
   idx_type          stk_rd_ff;

   // ------------------------------------------------------------------
   // Combinational control
   // ------------------------------------------------------------------
   logic            accept;
   logic            cell_zero;
   logic [CW-1:0]   addr_ext;
   logic [CW-1:0]   len_ext;
   logic [CW-1:0]   limit;
   logic [SC_W-1:0] cnt_m1;
   logic            prog_we, prog_re;
   logic            stk_we, stk_re;
   logic            scan_hit;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign cell_zero = (req_cell_value == '0);
   assign addr_ext  = CW'(req_address);
   assign len_ext   = CW'(len_ff);
   // scan stops at the smaller of program_length and the store depth
   assign limit     = (len_ext < PD_CW) ? len_ext : PD_CW;
   assign cnt_m1    = cnt_ff - SC_W'(1);
   // matching close bracket: a close seen at nesting depth zero
   assign scan_hit  = rd_vld_ff && (prog_rd_ff == CH_CLOSE) && (depth_ff == '0);

   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      depth_in     = depth_ff;
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_fault_in = rsp_fault_ff;
      prog_we      = 1'b0;
      prog_re      = 1'b0;
      stk_we       = 1'b0;
      stk_re       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in      = req_address;
               rsp_idx_in   = req_address;
               rsp_fault_in = FAULT_OK;
               case (req_kind)
                  KIND_LOAD: begin
                     // loads past the store are dropped but still answered
                     prog_we      = (addr_ext < PD_CW);
                     rsp_valid_in = 1'b1;
                  end
                  KIND_OPEN: begin
                     if (cell_zero) begin
                        state_in  = ST_SCAN;
                        rd_ptr_in = addr_ext + CW'(1);
                        depth_in  = '0;
                     end else if (cnt_ff == SD_FULL) begin
                        rsp_fault_in = FAULT_OVERFLOW;
                        rsp_valid_in = 1'b1;
                     end else begin
                        stk_we       = 1'b1;
                        cnt_in       = cnt_ff + SC_W'(1);
                        rsp_valid_in = 1'b1;
                     end
                  end
                  KIND_CLOSE: begin
                     if (cnt_ff == '0) begin
                        rsp_fault_in = FAULT_EMPTY;
                        rsp_valid_in = 1'b1;
                     end else if (!cell_zero) begin
                        // loop back: fetch top of stack, answer from the TOS state
                        stk_re   = 1'b1;
                        state_in = ST_TOS;
                     end else begin
                        cnt_in       = cnt_m1;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_TOS: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = stk_rd_ff;
            rsp_fault_in = FAULT_OK;
            state_in     = ST_IDLE;
         end

         ST_SCAN: begin
            if (scan_hit) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = rd_idx_ff;
               rsp_fault_in = FAULT_OK;
               state_in     = ST_IDLE;
            end else if (!rd_vld_ff && (rd_ptr_ff >= limit)) begin
               // nothing in flight and nothing left to fetch
               rsp_valid_in = 1'b1;
               rsp_idx_in   = addr_ff;
               rsp_fault_in = FAULT_NO_MATCH;
               state_in     = ST_IDLE;
            end else begin
               if (rd_vld_ff) begin
                  if (prog_rd_ff == CH_CLOSE) begin
                     depth_in = depth_ff - CW'(1);
                  end else if (prog_rd_ff == CH_OPEN) begin
                     depth_in = depth_ff + CW'(1);
                  end
               end
               if (rd_ptr_ff < limit) begin
                  prog_re   = 1'b1;
                  rd_vld_in = 1'b1;
                  rd_idx_in = rd_ptr_ff[IDX_W-1:0];
                  rd_ptr_in = rd_ptr_ff + CW'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Control and payload registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            len_ff <= csr_program_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      rd_ptr_ff    <= rd_ptr_in;
      rd_idx_ff    <= rd_idx_in;
      depth_ff     <= depth_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   // ------------------------------------------------------------------
   // Program store: one write port (loads), one read port (scan)
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[addr_ext[PA_W-1:0]] <= req_program_byte;
      end
      if (prog_re) begin
         prog_rd_ff <= prog_mem[rd_ptr_ff[PA_W-1:0]];
      end
   end

   // ------------------------------------------------------------------
   // Return stack: push writes at count, top read at count-1.
   // Push and top read never share a cycle, so no forwarding needed.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[cnt_ff[SI_W-1:0]] <= req_address;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[cnt_m1[SI_W-1:0]];
      end
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_next_index = rsp_idx_ff;
   assign rsp_fault      = rsp_fault_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= SD_FULL)
   `ASSERT_IMP(a_push_room, clock, reset, stk_we, cnt_ff < SD_FULL)
   `ASSERT_NXT(a_tos_one_cycle, clock, reset, state_ff == ST_TOS, state_ff == ST_IDLE)
   `ASSERT_NXT(a_nomatch_from_scan, clock, reset,
      (state_ff != ST_SCAN), !(rsp_valid_ff && (rsp_fault_ff == FAULT_NO_MATCH)))

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
   import blc_pkg::*;

   localparam int PROGRAM_DEPTH = 4096;
   localparam int STACK_DEPTH   = 64;

   // Program image regions the stimulus keeps fully written: a head at the
   // bottom of the store and a tail that ends at the last index.
   localparam int HEAD_LEN  = 256;
   localparam int TAIL_BASE = PROGRAM_DEPTH - 64;

   localparam int WORDS_PER_PHASE = 100;
   localparam int DRAIN_CYCLES    = 64;
   localparam int MAX_REPORTS     = 10;

   // Worst case per word: full-store scan plus the longest sender gap,
   // about 2000 words, then taken three times over (4 time units per cycle).
   localparam longint TIMEOUT = 64'd100_000_000;

   // Kind value the block treats as a no-op; the package leaves it unnamed.
   localparam kind_type KIND_UNUSED = 2'd3;

   typedef struct packed {
      idx_type   next_index;
      fault_type fault;
   } result_type;

   // ---------------------------------------------------------------
   // Clock, reset and block ports; every input starts at a known value.
   // ---------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   kind_type         req_kind = KIND_LOAD;
   idx_type          req_address = '0;
   byte_type         req_program_byte = '0;
   byte_type         req_cell_value = '0;
   logic             rsp_strobe;
   idx_type          rsp_next_index;
   fault_type        rsp_fault;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_program_length = '0;

   always #2 clock = ~clock;

   bracket_loop_controller_top #(
      .PROGRAM_DEPTH(PROGRAM_DEPTH),
      .STACK_DEPTH  (STACK_DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_address       (req_address),
      .req_program_byte  (req_program_byte),
      .req_cell_value    (req_cell_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_next_index    (rsp_next_index),
      .rsp_fault         (rsp_fault),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_program_length(csr_program_length)
   );

   // ---------------------------------------------------------------
   // Shadow state of the unit, updated at each accepted word or write.
   // ---------------------------------------------------------------
   bit [BYTE_W-1:0] prog_image   [PROGRAM_DEPTH];
   bit              prog_written [PROGRAM_DEPTH];
   idx_type         ret_stack    [STACK_DEPTH];
   int unsigned     stack_depth = 0;
   int unsigned     prog_len = 0;

   result_type pending_results[$];

   // Handshake bookkeeping between the sender and the monitor.
   int unsigned words_sent = 0;
   int unsigned words_seen = 0;
   int unsigned csr_writes_done = 0;
   int unsigned csr_writes_seen = 0;
   bit          start_q = 1'b0;
   bit          gaps_on = 1'b1;

   int unsigned error_count = 0;
   int unsigned n_checked = 0;
   int unsigned n_load = 0, n_match = 0, n_no_match = 0, n_push = 0;
   int unsigned n_overflow = 0, n_return = 0, n_pop = 0, n_empty = 0;
   int unsigned n_unused = 0;

   // Forward scan for the close bracket matching an open at addr.
   // Returns its index, or -1 when the scan hits the limit. blind flags a
   // scan that looks at a byte never loaded.
   function automatic int find_close(idx_type addr, output bit blind);
      int limit;
      int depth;
      int j;
      limit = (prog_len > PROGRAM_DEPTH) ? PROGRAM_DEPTH : int'(prog_len);
      depth = 0;
      blind = 1'b0;
      for (j = int'(addr) + 1; j < limit; j++) begin
         if (!prog_written[j])
            blind = 1'b1;
         if (prog_image[j] == CH_CLOSE) begin
            if (depth == 0)
               return j;
            depth--;
         end else if (prog_image[j] == CH_OPEN) begin
            depth++;
         end
      end
      return -1;
   endfunction

   // Expected result of one word; advances the shadow state.
   function automatic result_type resolve_word(kind_type kind, idx_type addr,
                                               byte_type pbyte, byte_type cell_val);
      result_type res;
      int         hit;
      bit         blind;
      res.next_index = addr;
      res.fault      = FAULT_OK;
      case (kind)
         KIND_LOAD: begin
            prog_image[addr]   = pbyte;
            prog_written[addr] = 1'b1;
            n_load++;
         end
         KIND_OPEN: begin
            if (cell_val == 0) begin
               hit = find_close(addr, blind);
               if (hit < 0) begin
                  res.fault = FAULT_NO_MATCH;
                  n_no_match++;
               end else begin
                  res.next_index = idx_type'(hit);
                  n_match++;
               end
            end else if (stack_depth >= STACK_DEPTH) begin
               res.fault = FAULT_OVERFLOW;
               n_overflow++;
            end else begin
               ret_stack[stack_depth] = addr;
               stack_depth++;
               n_push++;
            end
         end
         KIND_CLOSE: begin
            if (stack_depth == 0) begin
               res.fault = FAULT_EMPTY;
               n_empty++;
            end else if (cell_val != 0) begin
               res.next_index = ret_stack[stack_depth - 1];
               n_return++;
            end else begin
               stack_depth--;
               n_pop++;
            end
         end
         default: n_unused++;
      endcase
      return res;
   endfunction

   function automatic void note_failure(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s", $time, msg);
   endfunction

   // ---------------------------------------------------------------
   // Monitor: everything sampled here is the value before the edge.
   // Prediction goes first so a same-cycle result would still line up.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            prog_len = csr_program_length;
            csr_writes_seen++;
         end
         if (start && !busy) begin
            pending_results.insert(pending_results.size(),
                                   resolve_word(req_kind, req_address,
                                                req_program_byte, req_cell_value));
            words_seen++;
         end
         if (rsp_strobe) begin
            n_checked++;
            if (pending_results.size() == 0) begin
               note_failure($sformatf("unexpected result: next_index %0d fault %0d",
                                      rsp_next_index, rsp_fault));
            end else begin
               want = pending_results.pop_front();
               if (rsp_next_index !== want.next_index || rsp_fault !== want.fault)
                  note_failure($sformatf(
                     "mismatch: expected next_index %0d fault %0d, got %0d fault %0d",
                     want.next_index, want.fault, rsp_next_index, rsp_fault));
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------
   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int pick_gap();
      int unsigned r;
      if (!gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic lower_start();
      if (start_q) begin
         start   <= 1'b0;
         start_q  = 1'b0;
      end
   endtask

   // Drives one word, holds it until accepted, then waits for the monitor
   // to have predicted it so the next pick sees current shadow state.
   task automatic send_word(kind_type kind, idx_type addr, byte_type pbyte,
                            byte_type cell_val);
      int gap;
      req_kind         <= kind;
      req_address      <= addr;
      req_program_byte <= pbyte;
      req_cell_value   <= cell_val;
      start            <= 1'b1;
      start_q           = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      words_sent++;
      wait (words_seen == words_sent);
      gap = pick_gap();
      if (gap > 0) begin
         lower_start();
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender pause: nothing goes in until every result is back.
   task automatic drain_results();
      lower_start();
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Register write only while the unit is idle.
   task automatic write_program_length(int unsigned len);
      drain_results();
      csr_program_length <= LEN_W'(len);
      csr_valid          <= 1'b1;
      forever begin
         @(posedge clock);
         if (csr_ready)
            break;
      end
      csr_valid <= 1'b0;
      csr_writes_done++;
      wait (csr_writes_seen == csr_writes_done);
   endtask

   // ---------------------------------------------------------------
   // Random picks
   // ---------------------------------------------------------------
   // Bracket-heavy program text so scans nest and match.
   function automatic byte_type pick_program_byte();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 3)
         return CH_OPEN;
      if (r < 6)
         return CH_CLOSE;
      return byte_type'($urandom_range(0, 255));
   endfunction

   function automatic byte_type pick_nonzero_cell();
      if ($urandom_range(0, 9) == 0)
         return 8'hFF;
      return byte_type'($urandom_range(1, 255));
   endfunction

   function automatic idx_type pick_code_address();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return idx_type'($urandom_range(0, HEAD_LEN - 1));
      if (r < 90)
         return idx_type'($urandom_range(TAIL_BASE, PROGRAM_DEPTH - 1));
      return idx_type'($urandom_range(0, PROGRAM_DEPTH - 1));
   endfunction

   task automatic send_random_word();
      int unsigned r;
      int unsigned push_cut;
      idx_type     addr;
      byte_type    cell_val;
      bit          blind;
      int          hit;
      r        = $urandom_range(0, 99);
      // fewer pushes when the stack runs deep, so it keeps moving
      push_cut = (stack_depth > 48) ? 35 : 52;
      cell_val = ($urandom_range(0, 1) != 0) ? 8'h00 : pick_nonzero_cell();
      if (r < 15) begin
         addr = pick_code_address();
         send_word(KIND_LOAD, addr,
                   ($urandom_range(0, 3) == 0) ? byte_type'($urandom) : pick_program_byte(),
                   byte_type'($urandom));
      end else if (r < push_cut) begin
         addr = pick_code_address();
         // a scan must never look at a byte that was never loaded
         if (cell_val == 0) begin
            hit = find_close(addr, blind);
            if (blind)
               cell_val = pick_nonzero_cell();
         end
         send_word(KIND_OPEN, addr, byte_type'($urandom), cell_val);
      end else if (r < 94) begin
         send_word(KIND_CLOSE, idx_type'($urandom), byte_type'($urandom), cell_val);
      end else begin
         send_word(KIND_UNUSED, idx_type'($urandom), byte_type'($urandom),
                   byte_type'($urandom));
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Fresh from reset: empty stack, zero program length, unused kind.
   task automatic test_reset_state();
      send_word(KIND_CLOSE, 12'd0, 8'h00, 8'h00);
      send_word(KIND_CLOSE, 12'hFFF, 8'hFF, 8'hFF);
      send_word(KIND_OPEN, 12'd0, 8'h00, 8'h00);      // length 0: no match
      send_word(KIND_UNUSED, 12'hFFF, 8'hFF, 8'hFF);
   endtask

   // Small nested program "[[]]" NUL "[" FF "]]["; scans with and
   // without a match inside the length.
   task automatic test_nested_scan();
      byte_type text [10];
      text = '{CH_OPEN, CH_OPEN, CH_CLOSE, CH_CLOSE, 8'h00,
               CH_OPEN, 8'hFF, CH_CLOSE, CH_CLOSE, CH_OPEN};
      foreach (text[i])
         send_word(KIND_LOAD, idx_type'(i), text[i], 8'h00);
      write_program_length(10);
      send_word(KIND_OPEN, 12'd0, 8'h00, 8'h00);      // skips inner pair
      send_word(KIND_OPEN, 12'd1, 8'h00, 8'h00);
      send_word(KIND_OPEN, 12'd4, 8'h00, 8'h00);
      send_word(KIND_OPEN, 12'd9, 8'h00, 8'h00);      // runs into the limit
      send_word(KIND_OPEN, 12'hFFF, 8'h00, 8'h00);    // last index
   endtask

   // Push two, read the top back, pop, read again, pop, then underflow.
   task automatic test_stack_round_trip();
      send_word(KIND_OPEN, 12'd0, 8'h00, 8'h01);
      send_word(KIND_OPEN, 12'd5, 8'h00, 8'h80);
      send_word(KIND_CLOSE, 12'd7, 8'h00, 8'hFF);
      send_word(KIND_CLOSE, 12'd7, 8'h00, 8'h00);
      send_word(KIND_CLOSE, 12'd8, 8'h00, 8'h03);
      send_word(KIND_CLOSE, 12'd8, 8'h00, 8'h00);
      send_word(KIND_CLOSE, 12'd9, 8'h00, 8'h00);
   endtask

   // Head and tail of the store get random bracket text.
   task automatic test_program_fill();
      for (int i = 0; i < HEAD_LEN; i++)
         send_word(KIND_LOAD, idx_type'(i), pick_program_byte(), byte_type'($urandom));
      for (int i = TAIL_BASE; i < PROGRAM_DEPTH; i++)
         send_word(KIND_LOAD, idx_type'(i), pick_program_byte(), byte_type'($urandom));
   endtask

   // Fill the return stack, overflow it, read the top, unwind, underflow.
   task automatic test_stack_limits();
      drain_results();
      while (stack_depth < STACK_DEPTH)
         send_word(KIND_OPEN, idx_type'($urandom), byte_type'($urandom),
                   pick_nonzero_cell());
      send_word(KIND_OPEN, idx_type'($urandom), 8'h00, 8'h01);
      send_word(KIND_OPEN, 12'hFFF, 8'hFF, 8'hFF);
      repeat (3)
         send_word(KIND_CLOSE, idx_type'($urandom), byte_type'($urandom),
                   pick_nonzero_cell());
      while (stack_depth > 0)
         send_word(KIND_CLOSE, idx_type'($urandom), byte_type'($urandom), 8'h00);
      send_word(KIND_CLOSE, 12'd0, 8'h00, 8'h00);
      send_word(KIND_CLOSE, 12'hFFF, 8'hFF, 8'h01);
   endtask

   // Random words under a range of program lengths, extremes included.
   // Two phases run without any sender gaps.
   task automatic test_random_phases();
      int unsigned len;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       len = HEAD_LEN;
            1:       len = 0;
            2:       len = 1;
            3:       len = PROGRAM_DEPTH;
            4:       len = $urandom_range(2, HEAD_LEN);
            5:       len = PROGRAM_DEPTH - 1;
            6:       len = 37;
            default: len = PROGRAM_DEPTH;
         endcase
         write_program_length(len);
         gaps_on = (p != 2 && p != 5);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            send_random_word();
            if ($urandom_range(0, 99) == 0)
               drain_results();
         end
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_nested_scan();
      test_stack_round_trip();
      test_program_fill();
      test_stack_limits();
      test_random_phases();

      // all words in; wait out the tail, then look for stray strobes
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d words, %0d results: %0d loads, %0d scans matched, %0d unmatched",
               words_sent, n_checked, n_load, n_match, n_no_match);
      $display("  %0d pushes, %0d overflows, %0d top reads, %0d pops, %0d empty, %0d no-ops",
               n_push, n_overflow, n_return, n_pop, n_empty, n_unused);
      if (error_count == 0 && pending_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(TIMEOUT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
